[hdl/stdr_pkg.sv]
// Shared types, constants and arithmetic helpers of the sparse-transpose product block.
// Used by every module in hdl/; depends on nothing else.
`timescale 1ns / 1ps

package stdr_pkg;

   localparam int ROWS_DEFAULT      = 1024;
   localparam int MAX_LANES_DEFAULT = 4;
   localparam int LANES_HW          = 4;
   localparam int QUEUE_DEPTH       = 4;
   localparam int ROW_W             = 10;
   localparam int COL_W             = 16;
   localparam int VAL_W             = 32;
   localparam int ACC_W             = 64;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_NONZERO = 2'd1,
      MODE_EMPTY   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   localparam logic CSR_LANES_USED   = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   // One classified command for the back end.
   typedef struct packed {
      logic                                   add_en;
      logic                                   close;
      logic signed [VAL_W-1:0]                a_value;
      logic [LANES_HW-1:0][VAL_W-1:0]         x_value;
   } cmd_type;

   typedef struct packed {
      logic [LANES_HW-1:0] lane_mask;
      logic [COL_W-1:0]    column_count;
   } cfg_type;

   typedef struct packed {
      logic              clip;
      logic [VAL_W-1:0]  value;
   } narrow_type;

   // Clamp the lane count to 2..max_lanes and mark the lanes in use.
   function automatic logic [LANES_HW-1:0] lane_mask(logic [2:0] lanes, int unsigned max_lanes);
      int unsigned         eff;
      logic [LANES_HW-1:0] m;
      eff = 32'(lanes);
      if (eff < 2) eff = 2;
      if (eff > max_lanes) eff = max_lanes;
      for (int k = 0; k < LANES_HW; k++) begin
         m[k] = (k < eff);
      end
      return m;
   endfunction

   // 64-bit add that clips at the signed limits.
   function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                       logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   // Q32.32 to Q16.16: round to nearest, ties upward, then clip to 32 bits.
   function automatic narrow_type narrow_sum(logic signed [ACC_W-1:0] acc);
      logic signed [48:0] q;
      narrow_type         r;
      q = {acc[63], acc[63:16]} + 49'(acc[15]);
      r.clip = 1'b0;
      if (q > 49'sd2147483647) begin
         r.value = 32'h7FFF_FFFF;
         r.clip  = 1'b1;
      end else if (q < -49'sd2147483648) begin
         r.value = 32'h8000_0000;
         r.clip  = 1'b1;
      end else begin
         r.value = q[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/stdr_front.sv]
// Front end: accepts requests, keeps the x store, classifies requests into commands.
// Depends on stdr_pkg.
`timescale 1ns / 1ps

module stdr_front #(
   parameter int ROWS      = stdr_pkg::ROWS_DEFAULT,
   parameter int MAX_LANES = stdr_pkg::MAX_LANES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [9:0]                req_row_index,
   input  logic [1:0]                req_lane,
   input  logic signed [31:0]        req_x_value,
   input  logic signed [31:0]        req_a_value,
   input  logic                      req_last_in_column,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output stdr_pkg::cmd_type         cmd
);

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic                              accept;
   logic                              row_ok;
   logic                              lane_ok;
   logic [ROW_AW+stdr_pkg::ROW_W-1:0] row_wide;
   logic [ROW_AW-1:0]                 row_addr;
   logic                              is_load;
   logic                              is_nonzero;
   logic                              is_empty;

   logic                              f_valid_ff, f_valid_in;
   logic                              f_add_ff;
   logic                              f_close_ff;
   logic signed [31:0]                f_a_ff;
   logic [stdr_pkg::LANES_HW-1:0][31:0] x_rd;

   assign accept   = req_valid && req_ready;
   assign req_ready = !f_valid_ff || cmd_ready;
   assign row_wide = {{ROW_AW{1'b0}}, req_row_index};
   assign row_addr = row_wide[ROW_AW-1:0];
   assign row_ok   = (32'(req_row_index) < ROWS);
   assign lane_ok  = (32'(req_lane) < MAX_LANES);

   always_comb begin
      is_load    = 1'b0;
      is_nonzero = 1'b0;
      is_empty   = 1'b0;
      case (stdr_pkg::mode_type'(req_mode))
         stdr_pkg::MODE_LOAD:    is_load    = 1'b1;
         stdr_pkg::MODE_NONZERO: is_nonzero = 1'b1;
         stdr_pkg::MODE_EMPTY:   is_empty   = 1'b1;
         default:                ;
      endcase
   end

   // x store: one memory per lane, so a nonzero reads all lanes of its row at once
   for (genvar k = 0; k < stdr_pkg::LANES_HW; k++) begin : g_lane
      if (k < MAX_LANES) begin : g_mem
         logic [31:0] lane_mem_ff [ROWS];
         logic [31:0] rd_ff;
         always_ff @(posedge clock) begin
            if (accept && is_load && row_ok && lane_ok && (32'(req_lane) == k)) begin
               lane_mem_ff[row_addr] <= req_x_value;
            end
            if (accept && is_nonzero && row_ok) begin
               rd_ff <= lane_mem_ff[row_addr];
            end
         end
         assign x_rd[k] = rd_ff;
      end else begin : g_none
         assign x_rd[k] = '0;
      end
   end

   always_comb begin
      f_valid_in = f_valid_ff;
      if (accept) begin
         f_valid_in = is_nonzero || is_empty;
      end else if (cmd_ready) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_add_ff   <= is_nonzero && row_ok;
         f_close_ff <= is_empty || (is_nonzero && req_last_in_column);
         f_a_ff     <= req_a_value;
      end
   end

   assign cmd_valid     = f_valid_ff;
   assign cmd.add_en    = f_add_ff;
   assign cmd.close     = f_close_ff;
   assign cmd.a_value   = f_a_ff;
   assign cmd.x_value   = x_rd;

   assert property (@(posedge clock) disable iff (reset) !req_ready |-> f_valid_ff)
      else $error("front stalls with an empty stage");

endmodule

[hdl/stdr_queue.sv]
// Command queue between front and back end.
// Depends on stdr_pkg.
`timescale 1ns / 1ps

module stdr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  stdr_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output stdr_pkg::cmd_type pop_cmd
);

   localparam int PW = $clog2(stdr_pkg::QUEUE_DEPTH);

   stdr_pkg::cmd_type entry_ff [stdr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != (PW+1)'(stdr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(stdr_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ((wr_ptr_ff - rd_ptr_ff) == count_ff[PW-1:0]))
      else $error("queue pointers disagree with count");

endmodule

[hdl/stdr_back.sv]
// Back end: lane multiplies, saturating accumulation, column close and output register.
// Depends on stdr_pkg.
`timescale 1ns / 1ps

module stdr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  stdr_pkg::cfg_type      cfg,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  stdr_pkg::cmd_type      cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_column_index,
   output logic signed [31:0]     rsp_sum_lane0,
   output logic signed [31:0]     rsp_sum_lane1,
   output logic signed [31:0]     rsp_sum_lane2,
   output logic signed [31:0]     rsp_sum_lane3,
   output logic                   rsp_saturated
);

   localparam int L = stdr_pkg::LANES_HW;

   logic                         adv;
   logic                         s1_valid_ff;
   logic                         s1_close_ff;
   logic [L-1:0]                 s1_add_ff;
   logic signed [63:0]           s1_prod_ff [L];
   logic signed [63:0]           acc_ff [L];
   logic signed [63:0]           acc_in [L];
   logic signed [63:0]           sum_next [L];
   logic                         s2_valid_ff;
   logic signed [63:0]           s2_sum_ff [L];
   logic [15:0]                  s2_col_ff;
   logic [15:0]                  col_ff, col_in;
   logic [16:0]                  col_inc;
   logic                         rsp_valid_ff;
   logic [15:0]                  rsp_col_ff;
   logic [L-1:0][31:0]           rsp_sum_ff;
   logic                         rsp_sat_ff;
   logic [L-1:0][31:0]           lane_out;
   logic                         sat_any;
   stdr_pkg::narrow_type         nar [L];
   logic signed [31:0]           a_s;
   logic signed [31:0]           x_s [L];

   // whole back end moves together whenever the output register can take a value
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = adv;
   assign a_s       = cmd.a_value;

   always_comb begin
      for (int k = 0; k < L; k++) begin
         x_s[k] = cmd.x_value[k];
      end
   end

   // stage 1: one 32x32 product per lane
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_close_ff <= cmd.close;
         for (int k = 0; k < L; k++) begin
            s1_add_ff[k]  <= cmd.add_en && cfg.lane_mask[k];
            s1_prod_ff[k] <= a_s * x_s[k];
         end
      end
   end

   // stage 2: accumulate, close the column
   assign col_inc = {1'b0, col_ff} + 17'd1;

   always_comb begin
      col_in = col_ff;
      for (int k = 0; k < L; k++) begin
         sum_next[k] = s1_add_ff[k] ? stdr_pkg::sat_add(acc_ff[k], s1_prod_ff[k]) : acc_ff[k];
         acc_in[k]   = acc_ff[k];
      end
      if (adv && s1_valid_ff) begin
         for (int k = 0; k < L; k++) begin
            acc_in[k] = s1_close_ff ? 64'sd0 : sum_next[k];
         end
         if (s1_close_ff) begin
            col_in = (col_inc >= {1'b0, cfg.column_count}) ? 16'd0 : col_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            acc_ff[k] <= 64'sd0;
         end
         col_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < L; k++) begin
            acc_ff[k] <= acc_in[k];
         end
         col_ff <= col_in;
         if (adv) begin
            s2_valid_ff <= s1_valid_ff && s1_close_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_col_ff <= col_ff;
         for (int k = 0; k < L; k++) begin
            s2_sum_ff[k] <= sum_next[k];
         end
      end
   end

   // stage 3: round, clip and drop unused lanes
   always_comb begin
      sat_any = 1'b0;
      for (int k = 0; k < L; k++) begin
         nar[k] = stdr_pkg::narrow_sum(s2_sum_ff[k]);
         if (cfg.lane_mask[k]) begin
            lane_out[k] = nar[k].value;
            sat_any     = sat_any | nar[k].clip;
         end else begin
            lane_out[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_col_ff <= s2_col_ff;
         rsp_sum_ff <= lane_out;
         rsp_sat_ff <= sat_any;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_sum_lane0    = rsp_sum_ff[0];
   assign rsp_sum_lane1    = rsp_sum_ff[1];
   assign rsp_sum_lane2    = rsp_sum_ff[2];
   assign rsp_sum_lane3    = rsp_sum_ff[3];
   assign rsp_saturated    = rsp_sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff && s1_close_ff) |=>
      (acc_ff[0] == 64'sd0 && acc_ff[1] == 64'sd0 && acc_ff[2] == 64'sd0 && acc_ff[3] == 64'sd0))
      else $error("accumulators not cleared after column close");

endmodule

[hdl/sparse_transpose_times_dense_rows_top.sv]
// Top level of the sparse-transpose times dense-rows product y = A' * x'.
// Depends on stdr_pkg, stdr_front, stdr_queue and stdr_back.
//
//   Port group | Direction | Handshake           | Carries
//   req_*      | in        | req_valid/req_ready | load of x, nonzero of A, empty column
//   rsp_*      | out       | rsp_valid/rsp_ready | closed column: lane sums, clip flag
//   csr_*      | in        | csr_write_enable    | lanes_used (index 0), column_count (1)
//
// One request is taken every cycle while the response side keeps up; a closing request
// gives its response through the x store read, queue, multiply, accumulate and output stages.
// The rate is set by the single accumulate stage, which folds one nonzero per cycle.
// Synchronous active-high reset clears the accumulators, the column index and all valids;
// the x store holds nothing defined until loaded.
// A stalled response stalls the back end; the command queue then lets the front keep
// accepting until it fills.
`timescale 1ns / 1ps

module sparse_transpose_times_dense_rows_top #(
   parameter int ROWS      = stdr_pkg::ROWS_DEFAULT,
   parameter int MAX_LANES = stdr_pkg::MAX_LANES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_row_index,
   input  logic [1:0]         req_lane,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_a_value,
   input  logic               req_last_in_column,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_column_index,
   output logic signed [31:0] rsp_sum_lane0,
   output logic signed [31:0] rsp_sum_lane1,
   output logic signed [31:0] rsp_sum_lane2,
   output logic signed [31:0] rsp_sum_lane3,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data
);

   logic [2:0]            lanes_used_ff;
   logic [15:0]           column_count_ff;
   stdr_pkg::cfg_type     cfg;
   logic                  f_valid;
   logic                  f_ready;
   stdr_pkg::cmd_type     f_cmd;
   logic                  q_valid;
   logic                  q_ready;
   stdr_pkg::cmd_type     q_cmd;

   // configuration registers: write at once, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_used_ff   <= 3'd4;
         column_count_ff <= 16'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            stdr_pkg::CSR_LANES_USED:   lanes_used_ff   <= csr_write_data[2:0];
            stdr_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_write_data;
            default:                    ;
         endcase
      end
   end

   // clamp the lane count once; both the multiply and output stages use the mask
   assign cfg.lane_mask    = stdr_pkg::lane_mask(lanes_used_ff, MAX_LANES);
   assign cfg.column_count = column_count_ff;

   stdr_front #(
      .ROWS      (ROWS),
      .MAX_LANES (MAX_LANES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_row_index      (req_row_index),
      .req_lane           (req_lane),
      .req_x_value        (req_x_value),
      .req_a_value        (req_a_value),
      .req_last_in_column (req_last_in_column),
      .cmd_valid          (f_valid),
      .cmd_ready          (f_ready),
      .cmd                (f_cmd)
   );

   stdr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   stdr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd_valid        (q_valid),
      .cmd_ready        (q_ready),
      .cmd              (q_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_index (rsp_column_index),
      .rsp_sum_lane0    (rsp_sum_lane0),
      .rsp_sum_lane1    (rsp_sum_lane1),
      .rsp_sum_lane2    (rsp_sum_lane2),
      .rsp_sum_lane3    (rsp_sum_lane3),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
